FILE: src/slow_data_text_message_decoder_assert.svh
// Assertion macros for the port-level checker of the slow-data text decoder.
`ifndef SLOW_DATA_TEXT_MESSAGE_DECODER_ASSERT_SVH
`define SLOW_DATA_TEXT_MESSAGE_DECODER_ASSERT_SVH

// Check a property on every rising edge outside reset.
`define SDTMD_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define SDTMD_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/sdtmd_pkg.sv
// Package of the slow-data text message decoder: types, constants, helpers.
package sdtmd_pkg;

    localparam int MSG_LEN    = 20;
    localparam int CHAR_IDX_W = 5;
    localparam int CHAR_W     = 8;
    localparam int STAGE_W    = 4;

    localparam logic [STAGE_W-1:0] STAGE_FIRST = 4'd1;
    localparam logic [STAGE_W-1:0] STAGE_LAST  = 4'd8;

    localparam logic [7:0] SYNC_SEQ   = 8'h00;
    localparam logic [7:0] SYNC_BYTE0 = 8'h55;
    localparam logic [7:0] SYNC_BYTE1 = 8'h2d;
    localparam logic [7:0] SYNC_BYTE2 = 8'h16;

    localparam logic [7:0] HEADER_BASE = 8'h30;

    localparam logic [7:0] KEY_BYTE0 = 8'h70;
    localparam logic [7:0] KEY_BYTE1 = 8'h4f;
    localparam logic [7:0] KEY_BYTE2 = 8'h93;

    typedef struct packed {
        logic [7:0] frame_seq;
        logic [7:0] slow_byte0;
        logic [7:0] slow_byte1;
        logic [7:0] slow_byte2;
    } frame_t;

    typedef struct packed {
        logic                  text_valid;
        logic [CHAR_IDX_W-1:0] char_index;
        logic [CHAR_W-1:0]     text_char;
        logic                  last;
    } result_t;

    // Readout request: start one job, either a full message or one status result.
    typedef struct packed {
        logic start;
        logic text;
    } job_t;

    // First message position that a stage writes.
    function automatic logic [CHAR_IDX_W-1:0] block_base(input logic [STAGE_W-1:0] stage);
        logic [CHAR_IDX_W-1:0] base;
        unique case (stage)
            4'd2:    base = 5'd2;
            4'd3:    base = 5'd5;
            4'd4:    base = 5'd7;
            4'd5:    base = 5'd10;
            4'd6:    base = 5'd12;
            4'd7:    base = 5'd15;
            4'd8:    base = 5'd17;
            default: base = 5'd0;
        endcase
        return base;
    endfunction

endpackage

FILE: src/sdtmd_if.sv
// Valid/ready channel interfaces for voice frames and decoded results.
interface sdtmd_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_seq;
    logic [7:0] slow_byte0;
    logic [7:0] slow_byte1;
    logic [7:0] slow_byte2;

    modport source (output valid, output frame_seq, output slow_byte0, output slow_byte1,
                    output slow_byte2, input ready);
    modport sink   (input valid, input frame_seq, input slow_byte0, input slow_byte1,
                    input slow_byte2, output ready);
endinterface

interface sdtmd_result_if;
    logic                               valid;
    logic                               ready;
    logic                               text_valid;
    logic [sdtmd_pkg::CHAR_IDX_W-1:0]   char_index;
    logic [sdtmd_pkg::CHAR_W-1:0]       text_char;
    logic                               last;

    modport source (output valid, output text_valid, output char_index, output text_char,
                    output last, input ready);
    modport sink   (input valid, input text_valid, input char_index, input text_char,
                    input last, output ready);
endinterface

FILE: src/sdtmd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sdtmd_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 20
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/sdtmd_decoder.sv
// Frame decoder: sync and stage tracking, descramble, character writes.
module sdtmd_decoder (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  sdtmd_pkg::frame_t                 frame_data,
    output logic                              idle,
    output logic                              we,
    output logic [sdtmd_pkg::CHAR_IDX_W-1:0]  waddr,
    output logic [sdtmd_pkg::CHAR_W-1:0]      wdata,
    output sdtmd_pkg::job_t                   job
);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_WRITE = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic                              synced_reg, synced_next;
    logic [sdtmd_pkg::STAGE_W-1:0]     stage_reg, stage_next;
    logic                              done_reg, done_next;
    logic [1:0]                        left_reg, left_next;
    logic [1:0]                        pos_reg, pos_next;
    logic [sdtmd_pkg::CHAR_IDX_W-1:0]  base_reg;
    logic [sdtmd_pkg::CHAR_W-1:0]      chars_reg [3];

    logic       sync_hit;
    logic       stage_match;
    logic       odd_hit;
    logic       even_hit;
    logic [7:0] header;

    always_comb
    begin
        sync_hit = (frame_data.frame_seq  == sdtmd_pkg::SYNC_SEQ)
                && (frame_data.slow_byte0 == sdtmd_pkg::SYNC_BYTE0)
                && (frame_data.slow_byte1 == sdtmd_pkg::SYNC_BYTE1)
                && (frame_data.slow_byte2 == sdtmd_pkg::SYNC_BYTE2);
        stage_match = synced_reg
                   && (stage_reg >= sdtmd_pkg::STAGE_FIRST)
                   && (stage_reg <= sdtmd_pkg::STAGE_LAST)
                   && (frame_data.frame_seq == {4'd0, stage_reg});
        header   = sdtmd_pkg::HEADER_BASE + {5'd0, stage_reg[3:1]};
        odd_hit  = !sync_hit && stage_match && stage_reg[0]
                && (frame_data.slow_byte0 == header);
        even_hit = !sync_hit && stage_match && !stage_reg[0];
    end

    always_comb
    begin
        state_next  = state_reg;
        synced_next = synced_reg;
        stage_next  = stage_reg;
        done_next   = done_reg;
        left_next   = left_reg;
        pos_next    = pos_reg;
        job         = '0;
        we          = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_WRITE;
                    done_next  = 1'b0;
                    pos_next   = 2'd0;
                    left_next  = 2'd0;
                    if (sync_hit)
                    begin
                        synced_next = 1'b1;
                        stage_next  = sdtmd_pkg::STAGE_FIRST;
                    end
                    else if (odd_hit)
                    begin
                        left_next  = 2'd2;
                        stage_next = stage_reg + 4'd1;
                    end
                    else if (even_hit)
                    begin
                        left_next = 2'd3;
                        if (stage_reg == sdtmd_pkg::STAGE_LAST)
                        begin
                            synced_next = 1'b0;
                            stage_next  = '0;
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            stage_next = stage_reg + 4'd1;
                        end
                    end
                end
            end
            ST_WRITE:
            begin
                if (left_reg != 2'd0)
                begin
                    we        = 1'b1;
                    left_next = left_reg - 2'd1;
                    pos_next  = pos_reg + 2'd1;
                end
                else
                begin
                    // All characters are in memory: hand the result job to readout.
                    job.start  = 1'b1;
                    job.text   = done_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign waddr = base_reg + {3'd0, pos_reg};
    assign wdata = chars_reg[pos_reg];
    assign idle  = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            synced_reg <= 1'b0;
            stage_reg  <= '0;
            done_reg   <= 1'b0;
            left_reg   <= 2'd0;
            pos_reg    <= 2'd0;
        end
        else
        begin
            state_reg  <= state_next;
            synced_reg <= synced_next;
            stage_reg  <= stage_next;
            done_reg   <= done_next;
            left_reg   <= left_next;
            pos_reg    <= pos_next;
        end
    end

    // Latch descrambled characters and the target position on accept.
    always_ff @(posedge clk)
    begin
        if (accept && idle)
        begin
            base_reg <= sdtmd_pkg::block_base(stage_reg);
            if (stage_reg[0])
            begin
                chars_reg[0] <= frame_data.slow_byte1 ^ sdtmd_pkg::KEY_BYTE1;
                chars_reg[1] <= frame_data.slow_byte2 ^ sdtmd_pkg::KEY_BYTE2;
                chars_reg[2] <= '0;
            end
            else
            begin
                chars_reg[0] <= frame_data.slow_byte0 ^ sdtmd_pkg::KEY_BYTE0;
                chars_reg[1] <= frame_data.slow_byte1 ^ sdtmd_pkg::KEY_BYTE1;
                chars_reg[2] <= frame_data.slow_byte2 ^ sdtmd_pkg::KEY_BYTE2;
            end
        end
    end

endmodule

FILE: src/sdtmd_readout.sv
// Readout: walks the message memory and feeds results through an output register and skid.
module sdtmd_readout (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sdtmd_pkg::job_t                   job,
    output logic                              busy,
    output logic [sdtmd_pkg::CHAR_IDX_W-1:0]  raddr,
    input  logic [sdtmd_pkg::CHAR_W-1:0]      rdata,
    input  logic                              out_ready,
    output logic                              out_valid,
    output sdtmd_pkg::result_t                out_item
);

    localparam logic [sdtmd_pkg::CHAR_IDX_W-1:0] LAST_IDX =
        sdtmd_pkg::CHAR_IDX_W'(sdtmd_pkg::MSG_LEN - 1);

    logic                              active_reg;
    logic                              text_reg;
    logic [sdtmd_pkg::CHAR_IDX_W-1:0]  idx_reg;

    logic                              fl_valid_reg;
    logic                              fl_text_reg;
    logic                              fl_last_reg;
    logic [sdtmd_pkg::CHAR_IDX_W-1:0]  fl_idx_reg;

    logic                              out_valid_reg;
    sdtmd_pkg::result_t                out_item_reg;
    logic                              skid_valid_reg;
    sdtmd_pkg::result_t                skid_item_reg;

    logic               take;
    logic [1:0]         occ;
    logic               issue;
    logic               issue_last;
    sdtmd_pkg::result_t landing;

    always_comb
    begin
        take  = out_valid_reg && out_ready;
        occ   = 2'(out_valid_reg) + 2'(skid_valid_reg) + 2'(fl_valid_reg) - 2'(take);
        // Issue a read only when a slot is sure to be free as the data lands.
        issue = active_reg && (occ <= 2'd1);
        issue_last = !text_reg || (idx_reg == LAST_IDX);

        landing.text_valid = fl_text_reg;
        landing.char_index = fl_text_reg ? fl_idx_reg : '0;
        landing.text_char  = fl_text_reg ? rdata : '0;
        landing.last       = fl_last_reg;
    end

    assign raddr     = idx_reg;
    assign busy      = active_reg || fl_valid_reg || skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            fl_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (job.start)
            begin
                active_reg <= 1'b1;
            end
            else if (issue && issue_last)
            begin
                active_reg <= 1'b0;
            end
            fl_valid_reg <= issue;
            if (take || !out_valid_reg)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= fl_valid_reg;
                end
                else
                begin
                    out_valid_reg <= fl_valid_reg;
                end
            end
            else if (fl_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job.start)
        begin
            text_reg <= job.text;
            idx_reg  <= '0;
        end
        else if (issue)
        begin
            idx_reg <= idx_reg + 5'd1;
        end
        if (issue)
        begin
            fl_text_reg <= text_reg;
            fl_idx_reg  <= idx_reg;
            fl_last_reg <= issue_last;
        end
        if (take || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_item_reg  <= skid_item_reg;
                skid_item_reg <= landing;
            end
            else
            begin
                out_item_reg <= landing;
            end
        end
        else if (fl_valid_reg)
        begin
            skid_item_reg <= landing;
        end
    end

endmodule

FILE: src/slow_data_text_message_decoder.sv
// Top level of the slow-data text message decoder.
//
// Channels: frame (sink) takes one voice frame per transaction: the sequence
// byte and three scrambled slow-data bytes. result (source) gives one
// transaction per result: text_valid, char_index, text_char, last.
// Each frame yields one status transaction (text_valid 0, last 1), except the
// frame that completes a message, which yields the 20 characters in order
// with last on index 19.
// Path: once a frame is accepted, the decoder writes its characters (0, 2
// or 3) and hands a job to readout, which passes each result through its
// in-flight register and the output register. Flow: one frame is in work at
// a time. frame.ready rises again once the previous frame's results have all
// reached the output register. The message memory has one write port, so
// characters go in one per cycle, and readout reads it one character per
// cycle through its single read port while the output path has room.
// Reset clears sync and stage and empties the output path; the message
// memory is not cleared, since a message is only read after all 20
// characters have been written since the last sync.
// A stalled receiver holds the current result steady; readout pauses and
// resumes without loss through an output register and a one-entry skid.
module slow_data_text_message_decoder (
    input  logic                  clk,
    input  logic                  rst_n,
    sdtmd_frame_if.sink           frame,
    sdtmd_result_if.source        result
);

    logic                              accept;
    logic                              dec_idle;
    logic                              ro_busy;
    sdtmd_pkg::frame_t                 frame_data;
    sdtmd_pkg::job_t                   job;
    sdtmd_pkg::result_t                out_item;
    logic                              out_valid;
    logic                              we;
    logic [sdtmd_pkg::CHAR_IDX_W-1:0]  waddr;
    logic [sdtmd_pkg::CHAR_W-1:0]      wdata;
    logic [sdtmd_pkg::CHAR_IDX_W-1:0]  raddr;
    logic [sdtmd_pkg::CHAR_W-1:0]      rdata;

    // Take a frame only when the decoder is idle and readout has drained.
    assign frame.ready = dec_idle && !ro_busy;
    assign accept      = frame.valid && frame.ready;

    assign frame_data.frame_seq  = frame.frame_seq;
    assign frame_data.slow_byte0 = frame.slow_byte0;
    assign frame_data.slow_byte1 = frame.slow_byte1;
    assign frame_data.slow_byte2 = frame.slow_byte2;

    sdtmd_decoder u_decoder (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .frame_data (frame_data),
        .idle       (dec_idle),
        .we         (we),
        .waddr      (waddr),
        .wdata      (wdata),
        .job        (job)
    );

    // Message store: 20 characters, written by the decoder, read by readout.
    sdtmd_ram #(
        .DATA_W (sdtmd_pkg::CHAR_W),
        .DEPTH  (sdtmd_pkg::MSG_LEN)
    ) u_msg_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    sdtmd_readout u_readout (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job),
        .busy      (ro_busy),
        .raddr     (raddr),
        .rdata     (rdata),
        .out_ready (result.ready),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

    assign result.valid      = out_valid;
    assign result.text_valid = out_item.text_valid;
    assign result.char_index = out_item.char_index;
    assign result.text_char  = out_item.text_char;
    assign result.last       = out_item.last;

endmodule

FILE: src/sdtmd_checker.sv
// Port-level checker for the slow-data text message decoder, with its bind.
`include "slow_data_text_message_decoder_assert.svh"

module sdtmd_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic                              text_valid,
    input logic [sdtmd_pkg::CHAR_IDX_W-1:0]  char_index,
    input logic [sdtmd_pkg::CHAR_W-1:0]      text_char,
    input logic                              last
);

    `SDTMD_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(text_valid) && $stable(char_index) && $stable(text_char) && $stable(last), "result changed while stalled")
    `SDTMD_ASSERT(a_one_frame, clk, rst_n, in_valid && in_ready |=> !in_ready, "frame accepted while previous frame in work")
    `SDTMD_ASSERT(a_status_form, clk, rst_n, out_valid && !text_valid |-> last && (char_index == '0) && (text_char == '0), "malformed status result")
    `SDTMD_ASSERT(a_text_last, clk, rst_n, out_valid && text_valid |-> (last == (char_index == sdtmd_pkg::CHAR_IDX_W'(sdtmd_pkg::MSG_LEN - 1))), "last misplaced in message")
    `SDTMD_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |-> !out_valid, "result valid during reset")

endmodule

bind slow_data_text_message_decoder sdtmd_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (frame.valid),
    .in_ready   (frame.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .text_valid (result.text_valid),
    .char_index (result.char_index),
    .text_char  (result.text_char),
    .last       (result.last)
);

FILE: sim/decoder_checker.sv
// Checker for the slow-data text message decoder: predicts results and compares them.
`timescale 1ns / 1ps

module decoder_checker (
    input  logic    clk,
    input  logic    rst_n,
    sdtmd_frame_if  frame,
    sdtmd_result_if result,
    output int      error_count,
    output int      outstanding,
    output int      frames_seen,
    output int      messages_done
);

    logic                          locked;
    logic [sdtmd_pkg::STAGE_W-1:0] stage_now;
    logic [sdtmd_pkg::CHAR_W-1:0]  message_chars [sdtmd_pkg::MSG_LEN];
    sdtmd_pkg::result_t            pending_results [$];
    int                            fail_tally;
    int                            frame_tally;
    int                            message_tally;

    // First message position written by a stage.
    function automatic int first_char_pos(input logic [sdtmd_pkg::STAGE_W-1:0] s);
        if (s[0])
            return ((s - 1) >> 1) * 5;
        return ((s >> 1) - 1) * 5 + 2;
    endfunction

    task automatic note_failure(input string what);
        fail_tally++;
        $display("%0t ns: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
            note_failure($sformatf("%s mismatch: expected %h, actual %h", name, want, got));
    endtask

    // Advance the decoder state by one frame and queue the results it causes.
    task automatic decode_voice_frame(input sdtmd_pkg::frame_t f);
        int         pos;
        bit         complete;
        logic [7:0] header;
        complete = 1'b0;
        if (f.frame_seq == sdtmd_pkg::SYNC_SEQ && f.slow_byte0 == sdtmd_pkg::SYNC_BYTE0 &&
            f.slow_byte1 == sdtmd_pkg::SYNC_BYTE1 && f.slow_byte2 == sdtmd_pkg::SYNC_BYTE2)
        begin
            locked    = 1'b1;
            stage_now = sdtmd_pkg::STAGE_FIRST;
        end
        else if (locked && stage_now >= sdtmd_pkg::STAGE_FIRST &&
                 stage_now <= sdtmd_pkg::STAGE_LAST && f.frame_seq == {4'b0000, stage_now})
        begin
            pos = first_char_pos(stage_now);
            if (stage_now[0])
            begin
                header = sdtmd_pkg::HEADER_BASE + 8'((stage_now - 4'd1) >> 1);
                if (f.slow_byte0 == header)
                begin
                    message_chars[pos]     = f.slow_byte1 ^ sdtmd_pkg::KEY_BYTE1;
                    message_chars[pos + 1] = f.slow_byte2 ^ sdtmd_pkg::KEY_BYTE2;
                    stage_now              = stage_now + 4'd1;
                end
            end
            else
            begin
                message_chars[pos]     = f.slow_byte0 ^ sdtmd_pkg::KEY_BYTE0;
                message_chars[pos + 1] = f.slow_byte1 ^ sdtmd_pkg::KEY_BYTE1;
                message_chars[pos + 2] = f.slow_byte2 ^ sdtmd_pkg::KEY_BYTE2;
                if (stage_now == sdtmd_pkg::STAGE_LAST)
                begin
                    locked    = 1'b0;
                    stage_now = '0;
                    complete  = 1'b1;
                end
                else
                begin
                    stage_now = stage_now + 4'd1;
                end
            end
        end
        if (complete)
        begin
            message_tally++;
            for (int k = 0; k < sdtmd_pkg::MSG_LEN; k++)
                pending_results.push_back(sdtmd_pkg::result_t'{1'b1,
                                          sdtmd_pkg::CHAR_IDX_W'(k), message_chars[k],
                                          k == sdtmd_pkg::MSG_LEN - 1});
        end
        else
        begin
            pending_results.push_back(sdtmd_pkg::result_t'{1'b0, '0, '0, 1'b1});
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sdtmd_pkg::result_t want;
        if (!rst_n)
        begin
            locked    = 1'b0;
            stage_now = '0;
            for (int k = 0; k < sdtmd_pkg::MSG_LEN; k++)
                message_chars[k] = '0;
            pending_results.delete();
        end
        else
        begin
            // Compare first: a result at this edge always belongs to an older frame.
            if (result.valid && result.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    note_failure($sformatf("unexpected result: text_valid %b index %0d char %h last %b",
                                           result.text_valid, result.char_index,
                                           result.text_char, result.last));
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("text_valid", 8'(want.text_valid), 8'(result.text_valid));
                    check_field("char_index", 8'(want.char_index), 8'(result.char_index));
                    check_field("text_char", want.text_char, result.text_char);
                    check_field("last", 8'(want.last), 8'(result.last));
                end
            end
            if (frame.valid && frame.ready)
            begin
                frame_tally++;
                decode_voice_frame(sdtmd_pkg::frame_t'{frame.frame_seq, frame.slow_byte0,
                                                       frame.slow_byte1, frame.slow_byte2});
            end
        end
        error_count   <= fail_tally;
        outstanding   <= pending_results.size();
        frames_seen   <= frame_tally;
        messages_done <= message_tally;
    end

endmodule

FILE: sim/testbench.sv
// Top of the slow-data text message decoder testbench: clock, reset, stimulus, verdict.
`timescale 1ns / 1ps

module testbench;

    localparam int FRAME_TARGET = 470;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 12;

    // Receiver behavior; switched after a random stretch.
    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_PERIODIC,
        READY_SPARSE
    } ready_mode_t;

    logic clk;
    logic rst_n;

    sdtmd_frame_if  frame_ch ();
    sdtmd_result_if result_ch ();

    int error_count;
    int outstanding;
    int frames_seen;
    int messages_done;

    int          frames_sent;
    int          burst_left;
    int          idle_cycles;
    ready_mode_t ready_mode;
    int          ready_left;
    int          ready_tick;

    slow_data_text_message_decoder uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame_ch),
        .result (result_ch)
    );

    decoder_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .frame         (frame_ch),
        .result        (result_ch),
        .error_count   (error_count),
        .outstanding   (outstanding),
        .frames_seen   (frames_seen),
        .messages_done (messages_done)
    );

    // 8 ns clock: high and low halves of 4 ns each.
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Receiver: pick a stall pattern, hold it for a random stretch, then switch.
    // READY_ALWAYS gives stretches with no stalls at all.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            ready_mode      = READY_ALWAYS;
            ready_left      = 0;
            ready_tick      = 0;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (ready_left == 0)
            begin
                ready_mode = ready_mode_t'($urandom_range(0, 3));
                ready_left = $urandom_range(16, 96);
            end
            else
            begin
                ready_left--;
            end
            ready_tick++;
            unique case (ready_mode)
                READY_ALWAYS:   result_ch.ready <= 1'b1;
                READY_COIN:     result_ch.ready <= 1'($urandom_range(0, 1));
                READY_PERIODIC: result_ch.ready <= (ready_tick % 3 != 0);
                READY_SPARSE:   result_ch.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    function automatic sdtmd_pkg::frame_t make_frame(input logic [7:0] seq,
                                                     input logic [7:0] b0,
                                                     input logic [7:0] b1,
                                                     input logic [7:0] b2);
        return sdtmd_pkg::frame_t'{seq, b0, b1, b2};
    endfunction

    // Drive one frame and hold it until the decoder takes it. Between bursts, drop
    // valid for a random gap; a zero gap keeps valid high across the burst boundary.
    task automatic drive_frame(input sdtmd_pkg::frame_t f);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                frame_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        frame_ch.valid      <= 1'b1;
        frame_ch.frame_seq  <= f.frame_seq;
        frame_ch.slow_byte0 <= f.slow_byte0;
        frame_ch.slow_byte1 <= f.slow_byte1;
        frame_ch.slow_byte2 <= f.slow_byte2;
        do
            @(posedge clk);
        while (!frame_ch.ready);
        frames_sent++;
    endtask

    // Random frame; now and then keep the sequence near the stage range so that
    // stray frames can hit a live stage.
    function automatic sdtmd_pkg::frame_t noise_frame();
        logic [7:0] seq;
        seq = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 9)) : 8'($urandom);
        return make_frame(seq, 8'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    function automatic logic [7:0] stage_header(input int s);
        return sdtmd_pkg::HEADER_BASE + 8'((s - 1) >> 1);
    endfunction

    // One message attempt: sync, then eight stage frames with random text. Mix in
    // noise, frames with flag bits set, wrong headers and early aborts; the abort
    // leaves a partial message that the next sync overrides.
    task automatic send_message_attempt();
        sdtmd_pkg::frame_t f;
        drive_frame(make_frame(sdtmd_pkg::SYNC_SEQ, sdtmd_pkg::SYNC_BYTE0,
                               sdtmd_pkg::SYNC_BYTE1, sdtmd_pkg::SYNC_BYTE2));
        for (int s = 1; s <= 8; s++)
        begin
            if ($urandom_range(0, 9) == 0)
                drive_frame(noise_frame());
            if ($urandom_range(0, 19) == 0)
                drive_frame(make_frame(8'(s) | (8'h10 << $urandom_range(0, 3)),
                                       stage_header(s), 8'($urandom), 8'($urandom)));
            if (s % 2 == 1 && $urandom_range(0, 7) == 0)
                drive_frame(make_frame(8'(s), stage_header(s) ^ 8'($urandom_range(1, 255)),
                                       8'($urandom), 8'($urandom)));
            if ($urandom_range(0, 39) == 0)
                return;
            f = make_frame(8'(s), 8'($urandom), 8'($urandom), 8'($urandom));
            if (s % 2 == 1)
                f.slow_byte0 = stage_header(s);
            drive_frame(f);
        end
    endtask

    // Watchdog: end the run if no transaction moves on either side for too long.
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        // Drive reset and the frame channel to known values before the first edge.
        rst_n               = 1'b0;
        frame_ch.valid      = 1'b0;
        frame_ch.frame_seq  = '0;
        frame_ch.slow_byte0 = '0;
        frame_ch.slow_byte1 = '0;
        frame_ch.slow_byte2 = '0;
        frames_sent         = 0;
        burst_left          = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Before any sync: all-ones noise, then a stage 1 frame
        // that must be ignored because the decoder is not synced.
        drive_frame(make_frame(8'hff, 8'hff, 8'hff, 8'hff));
        drive_frame(make_frame(8'h01, sdtmd_pkg::HEADER_BASE, 8'h00, 8'h00));
        // Sync, then a stage 1 frame with a flag bit set and one with the wrong
        // header: both ignored.
        drive_frame(make_frame(sdtmd_pkg::SYNC_SEQ, sdtmd_pkg::SYNC_BYTE0,
                               sdtmd_pkg::SYNC_BYTE1, sdtmd_pkg::SYNC_BYTE2));
        drive_frame(make_frame(8'h41, sdtmd_pkg::HEADER_BASE, 8'h00, 8'h00));
        drive_frame(make_frame(8'h01, sdtmd_pkg::HEADER_BASE + 8'd1, 8'h00, 8'h00));
        // Stages 1 and 2, a stale stage 1 frame in between, then resync mid-message.
        drive_frame(make_frame(8'h01, sdtmd_pkg::HEADER_BASE, 8'h00, 8'hff));
        drive_frame(make_frame(8'h01, sdtmd_pkg::HEADER_BASE, 8'h12, 8'h34));
        drive_frame(make_frame(8'h02, 8'h00, 8'hff, 8'h00));
        drive_frame(make_frame(sdtmd_pkg::SYNC_SEQ, sdtmd_pkg::SYNC_BYTE0,
                               sdtmd_pkg::SYNC_BYTE1, sdtmd_pkg::SYNC_BYTE2));
        // Full message with extreme raw bytes and characters that descramble to zero.
        drive_frame(make_frame(8'h01, sdtmd_pkg::HEADER_BASE,        8'h00, 8'hff));
        drive_frame(make_frame(8'h02, 8'h00, 8'hff, 8'h00));
        drive_frame(make_frame(8'h03, sdtmd_pkg::HEADER_BASE + 8'd1, 8'hff, 8'h00));
        drive_frame(make_frame(8'h04, 8'hff, 8'h00, 8'hff));
        drive_frame(make_frame(8'h05, sdtmd_pkg::HEADER_BASE + 8'd2, 8'h55, 8'haa));
        drive_frame(make_frame(8'h06, 8'haa, 8'h55, 8'haa));
        drive_frame(make_frame(8'h07, sdtmd_pkg::HEADER_BASE + 8'd3,
                               sdtmd_pkg::KEY_BYTE1, sdtmd_pkg::KEY_BYTE2));
        drive_frame(make_frame(8'h08, sdtmd_pkg::KEY_BYTE0, sdtmd_pkg::KEY_BYTE1,
                               sdtmd_pkg::KEY_BYTE2));
        // After completion: a stage 8 repeat and near-sync frames change nothing.
        drive_frame(make_frame(8'h08, 8'h00, 8'h00, 8'h00));
        drive_frame(make_frame(sdtmd_pkg::SYNC_SEQ, sdtmd_pkg::SYNC_BYTE0,
                               sdtmd_pkg::SYNC_BYTE1, sdtmd_pkg::SYNC_BYTE2 ^ 8'h01));
        drive_frame(make_frame(8'h80, sdtmd_pkg::SYNC_BYTE0, sdtmd_pkg::SYNC_BYTE1,
                               sdtmd_pkg::SYNC_BYTE2));

        // Random part: mostly well-formed messages, some pure noise.
        while (frames_sent < FRAME_TARGET)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                repeat ($urandom_range(1, 4))
                    drive_frame(noise_frame());
            end
            else
            begin
                send_message_attempt();
            end
        end

        // Drain: release valid, let the last frame's results show up in the
        // count, wait for every expected result, then a short tail to catch
        // anything extra.
        frame_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d frames and %0d completed messages", frames_seen,
                 messages_done);
        $display("with resyncs, flagged and stray frames, random sender gaps and receiver stalls");
        if (error_count == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
